// File: design/dlbp_pkg.sv
package dlbp_pkg;

    localparam int FUNC_W   = 2;
    localparam int VALUE_W  = 25;
    localparam int COUNT_W  = 5;
    localparam int BYTE_W   = 8;
    localparam int CAP_W    = 24;
    localparam int STATUS_W = 2;
    localparam int NBYTES_W = 3;

    localparam int MAX_WRITE_BITS = 25;
    localparam int MAX_CODE_BITS  = 15;
    localparam int MAX_BYTES      = 6;

    localparam logic [FUNC_W-1:0] FUNC_RAW   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_HUFF  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_SYNC  = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAIL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVF  = 2'd2;

    localparam logic [COUNT_W-1:0] SYNC_HDR_BITS = 5'd3;
    localparam logic [COUNT_W-1:0] SYNC_LEN_BITS = 5'd16;
    localparam logic [VALUE_W-1:0] SYNC_LEN      = 25'h0000000;
    localparam logic [VALUE_W-1:0] SYNC_NLEN     = 25'h000FFFF;

    function automatic logic [VALUE_W-1:0] mask_value(
        input logic [VALUE_W-1:0] val,
        input logic [COUNT_W-1:0] cnt
    );
        logic [VALUE_W:0] m;
        m = ((VALUE_W+1)'(1) << cnt) - (VALUE_W+1)'(1);
        return val & m[VALUE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] reverse_code(
        input logic [VALUE_W-1:0] val,
        input logic [COUNT_W-1:0] cnt
    );
        logic [VALUE_W-1:0] r;
        r = '0;
        for (int i = 0; i < MAX_CODE_BITS; i++)
        begin
            if (COUNT_W'(i) < cnt)
            begin
                r[i] = val[cnt - COUNT_W'(i) - COUNT_W'(1)];
            end
        end
        return r;
    endfunction

endpackage

// File: design/dlbp_shifter.sv
module dlbp_shifter #(
    parameter int ACC_BITS = 64
) (
    input  logic [ACC_BITS-1:0]               acc,
    input  logic [dlbp_pkg::VALUE_W-1:0]      value,
    input  logic [$clog2(ACC_BITS+1)-1:0]     shamt,
    output logic [ACC_BITS-1:0]               inserted,
    output logic [ACC_BITS-1:0]               drained
);

    logic [ACC_BITS-1:0] value_ext;

    assign value_ext = {{(ACC_BITS-dlbp_pkg::VALUE_W){1'b0}}, value};
    assign inserted  = acc | (value_ext << shamt);
    assign drained   = acc >> dlbp_pkg::BYTE_W;

endmodule

// File: design/deflate_lsb_bit_packer.sv
// Sequential bit packer: one command at a time, one result transaction per cycle at most.
// A raw or Huffman write goes insert, drain, final (overflow skips the drain, a bad length
// goes to final); pad: pad, final; sync flush: header, pad, LEN, NLEN, pad, final.
// The next command is taken the cycle after the final result loads; back-pressure adds cycles.
// Asynchronous active-low reset clears accumulator, pending count, byte count,
// capacity and the output valid; a capacity write clears the stream state.
module deflate_lsb_bit_packer #(
    parameter int ACC_BITS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dlbp_pkg::CAP_W-1:0]        out_capacity,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [dlbp_pkg::FUNC_W-1:0]       func,
    input  logic [dlbp_pkg::VALUE_W-1:0]      bit_value,
    input  logic [dlbp_pkg::COUNT_W-1:0]      bit_count,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [dlbp_pkg::BYTE_W-1:0]       out_byte,
    output logic                              byte_valid,
    output logic [dlbp_pkg::STATUS_W-1:0]     status,
    output logic [dlbp_pkg::CAP_W-1:0]        bytes_total,
    output logic                              last
);

    localparam int PW = $clog2(ACC_BITS + 1);
    localparam logic [PW:0]   ACC_LIMIT = (PW+1)'(ACC_BITS);
    localparam logic [PW-1:0] BYTE_BITS = PW'(dlbp_pkg::BYTE_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_DRAIN,
        S_PAD,
        S_FINAL
    } state_t;

    typedef enum logic [2:0] {
        STEP_HDR,
        STEP_PAD1,
        STEP_LEN,
        STEP_NLEN,
        STEP_PAD2
    } step_t;

    state_t                          state_reg, state_next;
    step_t                           step_reg, step_next;
    logic [ACC_BITS-1:0]             acc_reg, acc_next;
    logic [PW-1:0]                   pend_reg, pend_next;
    logic [dlbp_pkg::CAP_W-1:0]      bw_reg, bw_next;
    logic [dlbp_pkg::CAP_W-1:0]      cap_reg, cap_next;
    logic [dlbp_pkg::FUNC_W-1:0]     func_reg, func_next;
    logic [dlbp_pkg::VALUE_W-1:0]    opv_reg, opv_next;
    logic [dlbp_pkg::COUNT_W-1:0]    opn_reg, opn_next;
    logic [dlbp_pkg::NBYTES_W-1:0]   nbytes_reg, nbytes_next;
    logic                            lost_reg, lost_next;
    logic [dlbp_pkg::STATUS_W-1:0]   stat_reg, stat_next;

    logic                            out_valid_reg, out_valid_next;
    logic [dlbp_pkg::BYTE_W-1:0]     out_byte_reg, out_byte_next;
    logic                            byte_valid_reg, byte_valid_next;
    logic [dlbp_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [dlbp_pkg::CAP_W-1:0]      bytes_total_reg, bytes_total_next;
    logic                            last_reg, last_next;

    logic [ACC_BITS-1:0]             acc_inserted;
    logic [ACC_BITS-1:0]             acc_drained;
    logic [PW:0]                     pend_sum;
    logic                            load_ok;
    logic                            step_done;
    logic                            room;

    dlbp_shifter #(
        .ACC_BITS (ACC_BITS)
    ) u_shifter (
        .acc      (acc_reg),
        .value    (opv_reg),
        .shamt    (pend_reg),
        .inserted (acc_inserted),
        .drained  (acc_drained)
    );

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign load_ok   = !out_valid_reg || out_ready;
    assign pend_sum  = {1'b0, pend_reg} + (PW+1)'(opn_reg);
    assign room      = (bw_reg < cap_reg)
                       && (nbytes_reg < dlbp_pkg::NBYTES_W'(dlbp_pkg::MAX_BYTES));

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        acc_next         = acc_reg;
        pend_next        = pend_reg;
        bw_next          = bw_reg;
        cap_next         = cap_reg;
        func_next        = func_reg;
        opv_next         = opv_reg;
        opn_next         = opn_reg;
        nbytes_next      = nbytes_reg;
        lost_next        = lost_reg;
        stat_next        = stat_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_byte_next    = out_byte_reg;
        byte_valid_next  = byte_valid_reg;
        status_next      = status_reg;
        bytes_total_next = bytes_total_reg;
        last_next        = last_reg;
        step_done        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cap_next  = out_capacity;
                    acc_next  = '0;
                    pend_next = '0;
                    bw_next   = '0;
                end
                else if (in_valid)
                begin
                    func_next   = func;
                    nbytes_next = '0;
                    lost_next   = 1'b0;
                    stat_next   = dlbp_pkg::STATUS_OK;
                    unique case (func)
                        dlbp_pkg::FUNC_RAW:
                        begin
                            if (bit_count == '0 || bit_count >
                                dlbp_pkg::COUNT_W'(dlbp_pkg::MAX_WRITE_BITS))
                            begin
                                stat_next  = dlbp_pkg::STATUS_FAIL;
                                state_next = S_FINAL;
                            end
                            else
                            begin
                                opv_next   = dlbp_pkg::mask_value(bit_value, bit_count);
                                opn_next   = bit_count;
                                state_next = S_INSERT;
                            end
                        end
                        dlbp_pkg::FUNC_HUFF:
                        begin
                            if (bit_count == '0 || bit_count >
                                dlbp_pkg::COUNT_W'(dlbp_pkg::MAX_CODE_BITS))
                            begin
                                stat_next  = dlbp_pkg::STATUS_FAIL;
                                state_next = S_FINAL;
                            end
                            else
                            begin
                                opv_next   = dlbp_pkg::reverse_code(bit_value, bit_count);
                                opn_next   = bit_count;
                                state_next = S_INSERT;
                            end
                        end
                        dlbp_pkg::FUNC_FLUSH:
                        begin
                            state_next = S_PAD;
                        end
                        dlbp_pkg::FUNC_SYNC:
                        begin
                            opv_next   = '0;
                            opn_next   = dlbp_pkg::SYNC_HDR_BITS;
                            step_next  = STEP_HDR;
                            state_next = S_INSERT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_INSERT:
            begin
                if (pend_sum > ACC_LIMIT)
                begin
                    lost_next = 1'b1;
                    stat_next = dlbp_pkg::STATUS_OVF;
                    step_done = 1'b1;
                end
                else
                begin
                    acc_next   = acc_inserted;
                    pend_next  = pend_sum[PW-1:0];
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (pend_reg >= BYTE_BITS)
                begin
                    if (bw_reg >= cap_reg)
                    begin
                        lost_next = 1'b1;
                        stat_next = dlbp_pkg::STATUS_FAIL;
                        step_done = 1'b1;
                    end
                    else if (nbytes_reg >= dlbp_pkg::NBYTES_W'(dlbp_pkg::MAX_BYTES))
                    begin
                        step_done = 1'b1;
                    end
                    else if (load_ok)
                    begin
                        out_valid_next   = 1'b1;
                        out_byte_next    = acc_reg[dlbp_pkg::BYTE_W-1:0];
                        byte_valid_next  = 1'b1;
                        status_next      = dlbp_pkg::STATUS_OK;
                        bytes_total_next = '0;
                        last_next        = 1'b0;
                        acc_next         = acc_drained;
                        pend_next        = pend_reg - BYTE_BITS;
                        bw_next          = bw_reg + dlbp_pkg::CAP_W'(1);
                        nbytes_next      = nbytes_reg + dlbp_pkg::NBYTES_W'(1);
                    end
                end
                else
                begin
                    step_done = 1'b1;
                end
            end

            S_PAD:
            begin
                if (pend_reg == '0)
                begin
                    step_done = 1'b1;
                end
                else if (!room)
                begin
                    lost_next = 1'b1;
                    acc_next  = '0;
                    pend_next = '0;
                    step_done = 1'b1;
                end
                else if (load_ok)
                begin
                    out_valid_next   = 1'b1;
                    out_byte_next    = acc_reg[dlbp_pkg::BYTE_W-1:0];
                    byte_valid_next  = 1'b1;
                    status_next      = dlbp_pkg::STATUS_OK;
                    bytes_total_next = '0;
                    last_next        = 1'b0;
                    bw_next          = bw_reg + dlbp_pkg::CAP_W'(1);
                    nbytes_next      = nbytes_reg + dlbp_pkg::NBYTES_W'(1);
                    acc_next         = '0;
                    pend_next        = '0;
                    step_done        = 1'b1;
                end
            end

            S_FINAL:
            begin
                if (load_ok)
                begin
                    out_valid_next   = 1'b1;
                    out_byte_next    = '0;
                    byte_valid_next  = 1'b0;
                    bytes_total_next = bw_reg;
                    last_next        = 1'b1;
                    if (func_reg == dlbp_pkg::FUNC_FLUSH || func_reg == dlbp_pkg::FUNC_SYNC)
                    begin
                        status_next = lost_reg ? dlbp_pkg::STATUS_FAIL : dlbp_pkg::STATUS_OK;
                    end
                    else
                    begin
                        status_next = stat_reg;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance the sync flush program, or finish the command
        if (step_done)
        begin
            if (func_reg == dlbp_pkg::FUNC_SYNC)
            begin
                unique case (step_reg)
                    STEP_HDR:
                    begin
                        step_next  = STEP_PAD1;
                        state_next = S_PAD;
                    end
                    STEP_PAD1:
                    begin
                        opv_next   = dlbp_pkg::SYNC_LEN;
                        opn_next   = dlbp_pkg::SYNC_LEN_BITS;
                        step_next  = STEP_LEN;
                        state_next = S_INSERT;
                    end
                    STEP_LEN:
                    begin
                        opv_next   = dlbp_pkg::SYNC_NLEN;
                        opn_next   = dlbp_pkg::SYNC_LEN_BITS;
                        step_next  = STEP_NLEN;
                        state_next = S_INSERT;
                    end
                    STEP_NLEN:
                    begin
                        step_next  = STEP_PAD2;
                        state_next = S_PAD;
                    end
                    STEP_PAD2:
                    begin
                        state_next = S_FINAL;
                    end
                    default:
                    begin
                        state_next = S_FINAL;
                    end
                endcase
            end
            else
            begin
                state_next = S_FINAL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            step_reg        <= STEP_HDR;
            acc_reg         <= '0;
            pend_reg        <= '0;
            bw_reg          <= '0;
            cap_reg         <= '0;
            func_reg        <= dlbp_pkg::FUNC_RAW;
            nbytes_reg      <= '0;
            lost_reg        <= 1'b0;
            stat_reg        <= dlbp_pkg::STATUS_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            acc_reg         <= acc_next;
            pend_reg        <= pend_next;
            bw_reg          <= bw_next;
            cap_reg         <= cap_next;
            func_reg        <= func_next;
            nbytes_reg      <= nbytes_next;
            lost_reg        <= lost_next;
            stat_reg        <= stat_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opv_reg         <= opv_next;
        opn_reg         <= opn_next;
        out_byte_reg    <= out_byte_next;
        byte_valid_reg  <= byte_valid_next;
        status_reg      <= status_next;
        bytes_total_reg <= bytes_total_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign status      = status_reg;
    assign bytes_total = bytes_total_reg;
    assign last        = last_reg;

    ap_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pend_reg} <= ACC_LIMIT)
        else $error("pending bit count exceeds accumulator");

    ap_byte_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (!last && status == dlbp_pkg::STATUS_OK
                                       && bytes_total == '0))
        else $error("byte transaction carries final fields");

    ap_final_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (!byte_valid && out_byte == '0))
        else $error("final transaction carries a byte");

    ap_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second command accepted while busy");

endmodule
